### hdl/sqts_pkg.sv
// Shared constants, types and helpers for the slot quota task scheduler.
// No dependencies; imported by slot_quota_task_scheduler.
`default_nettype none

package sqts_pkg;

	localparam int TASK_SLOTS  = 16;
	localparam int SLOT_IDX_W  = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
	localparam int HANDLE_W    = 32;
	localparam int COUNT_W     = 3;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 3;

	localparam logic [CFG_IDX_W-1:0] REG_QUOTA       = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INSERT_USED = 1'd1;

	localparam logic [COUNT_W-1:0] QUOTA_RESET       = 3'd3;
	localparam logic [COUNT_W-1:0] INSERT_USED_RESET = 3'd4;

	localparam int IN_USER_W  = 1;
	localparam int OUT_USER_W = 2;
	localparam int OP_BIT      = 0;
	localparam int PICKED_BIT  = 0;
	localparam int DROPPED_BIT = 1;

	localparam logic OP_ADD    = 1'b0;
	localparam logic OP_SWITCH = 1'b1;

	typedef logic [TASK_SLOTS-1:0] slot_vec_t;
	typedef logic [SLOT_IDX_W-1:0] slot_idx_t;
	typedef logic [HANDLE_W-1:0]   handle_t;
	typedef logic [COUNT_W-1:0]    count_t;

	// lowest set bit of the vector; zero when none is set
	function automatic slot_idx_t lowest_one(input slot_vec_t v);
		slot_idx_t idx;
		idx = '0;
		for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
			if (v[i]) begin
				idx = SLOT_IDX_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

`default_nettype wire

### hdl/slot_quota_task_scheduler.sv
// Slot quota task scheduler: slot table with per-slot used-counts and a quota pick.
// Depends on sqts_pkg for sizes, register indexes and the priority encoder.
//
// One transaction is taken at a time. An add item passes through accept, insert and result
// load. A switch item passes through accept, insert, search, a read of the picked handle
// and result load; one that finds nothing on the first search clears the used-counts and
// searches again, then goes on to the read if it picks, else straight to the result load.
// The read state after a pick comes from the registered read of the task handle RAM.
// The result load waits while an earlier result still waits on m_tready. The next
// transaction is accepted in the cycle after the result is loaded, even while that result
// still waits on m_tready. Busy bits and used-counts sit in flip-flops cleared by reset;
// handles live in a TASK_SLOTS x 32 RAM whose read data is used only for a slot that held
// a task when picked, so no clearing pass is needed.
`default_nettype none

module slot_quota_task_scheduler (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [sqts_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [sqts_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// task_handle[31:0]
	input  wire logic [sqts_pkg::HANDLE_W-1:0]   s_tdata,
	// operation[0]
	input  wire logic [sqts_pkg::IN_USER_W-1:0]  s_tuser,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// next_task[31:0]
	output logic [sqts_pkg::HANDLE_W-1:0]        m_tdata,
	// picked[0], insert_dropped[1]
	output logic [sqts_pkg::OUT_USER_W-1:0]      m_tuser
);
	import sqts_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INSERT,
		S_SEARCH,
		S_READ,
		S_FINISH
	} state_t;

	state_t    state_q;
	logic      op_q;
	handle_t   handle_q;
	count_t    quota_q;
	count_t    insert_used_q;
	slot_vec_t busy_q;
	count_t    used_q [TASK_SLOTS];
	slot_idx_t pick_idx_q;
	logic      pass_q;
	logic      got_q;
	logic      dropped_q;
	logic      out_valid_q;
	handle_t   out_task_q;
	logic      out_picked_q;
	logic      out_dropped_q;

	handle_t   task_mem [TASK_SLOTS];
	handle_t   task_rd_q;

	slot_vec_t free_vec;
	slot_vec_t elig_vec;
	slot_idx_t free_idx;
	slot_idx_t elig_idx;
	logic      mem_we;
	logic      out_free;

	always_comb begin
		free_vec = ~busy_q;
		for (int i = 0; i < TASK_SLOTS; i++) begin
			elig_vec[i] = busy_q[i] && (used_q[i] < quota_q);
		end
		free_idx = lowest_one(free_vec);
		elig_idx = lowest_one(elig_vec);
	end

	assign mem_we   = (state_q == S_INSERT) && (handle_q != '0) && (|free_vec);
	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			task_mem[free_idx] <= handle_q;
		end
		task_rd_q <= task_mem[pick_idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			op_q          <= OP_ADD;
			handle_q      <= '0;
			quota_q       <= QUOTA_RESET;
			insert_used_q <= INSERT_USED_RESET;
			busy_q        <= '0;
			for (int i = 0; i < TASK_SLOTS; i++) begin
				used_q[i] <= '0;
			end
			pick_idx_q    <= '0;
			pass_q        <= 1'b0;
			got_q         <= 1'b0;
			dropped_q     <= 1'b0;
			out_valid_q   <= 1'b0;
			out_task_q    <= '0;
			out_picked_q  <= 1'b0;
			out_dropped_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_QUOTA:       quota_q       <= cfg_wdata;
					REG_INSERT_USED: insert_used_q <= cfg_wdata;
				endcase
			end
			if (out_valid_q && m_tready && (state_q != S_FINISH)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						op_q     <= s_tuser[OP_BIT];
						handle_q <= s_tdata;
						pass_q   <= 1'b0;
						got_q    <= 1'b0;
						state_q  <= S_INSERT;
					end
				end
				S_INSERT: begin
					dropped_q <= (handle_q != '0) && !(|free_vec);
					if (mem_we) begin
						busy_q[free_idx] <= 1'b1;
						used_q[free_idx] <= insert_used_q;
					end
					state_q <= (op_q == OP_SWITCH) ? S_SEARCH : S_FINISH;
				end
				S_SEARCH: begin
					if (|elig_vec) begin
						used_q[elig_idx] <= used_q[elig_idx] + 1'b1;
						busy_q[elig_idx] <= 1'b0;
						pick_idx_q       <= elig_idx;
						got_q            <= 1'b1;
						state_q          <= S_READ;
					end else begin
						// clear all used-counts, retry once
						for (int i = 0; i < TASK_SLOTS; i++) begin
							used_q[i] <= '0;
						end
						pass_q  <= 1'b1;
						state_q <= pass_q ? S_FINISH : S_SEARCH;
					end
				end
				S_READ: begin
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (out_free) begin
						out_valid_q   <= 1'b1;
						out_task_q    <= got_q ? task_rd_q : '0;
						out_picked_q  <= got_q;
						out_dropped_q <= dropped_q;
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_tready              = (state_q == S_IDLE);
	assign m_tvalid              = out_valid_q;
	assign m_tdata               = out_task_q;
	assign m_tuser[PICKED_BIT]   = out_picked_q;
	assign m_tuser[DROPPED_BIT]  = out_dropped_q;

	a_picked_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[PICKED_BIT] |-> m_tdata != '0)
		else $error("picked result carries a zero handle");

	a_unpicked_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[PICKED_BIT] |-> m_tdata == '0)
		else $error("unpicked result carries a handle");

	a_pick_frees_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SEARCH) && (|elig_vec) |=> !busy_q[pick_idx_q])
		else $error("picked slot still busy");

	a_pick_under_quota: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SEARCH) && (|elig_vec) |-> used_q[elig_idx] < quota_q)
		else $error("pick exceeds quota");

endmodule

`default_nettype wire
